[rtl/lwcs_pkg.sv]
// Shared types, command codes and panel constants for the LCD window command stream.
// No dependencies; every other file of the block imports this package.
package lwcs_pkg;

	// Controller RAM geometry.
	localparam int RAM_COLUMNS = 240;
	localparam int RAM_ROWS    = 320;
	localparam int RAM_MAX     = (RAM_ROWS > RAM_COLUMNS) ? RAM_ROWS : RAM_COLUMNS;
	localparam int OFF_W       = $clog2(RAM_MAX + 1);

	// Panel size that gets centered offsets.
	localparam logic [8:0] ODD_SIZE = 9'd135;

	// Command queue between the front and back ends.
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Request actions.
	localparam logic [2:0] ACT_FILL   = 3'd0;
	localparam logic [2:0] ACT_DRAW   = 3'd1;
	localparam logic [2:0] ACT_NEXT   = 3'd2;
	localparam logic [2:0] ACT_INVERT = 3'd3;
	localparam logic [2:0] ACT_ORIENT = 3'd4;

	// Controller commands.
	localparam logic [7:0] OP_CASET  = 8'h2A;
	localparam logic [7:0] OP_RASET  = 8'h2B;
	localparam logic [7:0] OP_RAMWR  = 8'h2C;
	localparam logic [7:0] OP_MADCTL = 8'h36;
	localparam logic [7:0] OP_INVON  = 8'h21;
	localparam logic [7:0] OP_INVOFF = 8'h20;

	// Orientation byte bits.
	localparam logic [7:0] ORI_MY  = 8'h80;
	localparam logic [7:0] ORI_MX  = 8'h40;
	localparam logic [7:0] ORI_MV  = 8'h20;
	localparam logic [7:0] ORI_BGR = 8'h08;

	// Register indexes on the configuration port.
	localparam logic [1:0] REG_PANEL_WIDTH  = 2'd0;
	localparam logic [1:0] REG_PANEL_HEIGHT = 2'd1;
	localparam logic [1:0] REG_ROTATION     = 2'd2;

	typedef struct packed {
		logic [7:0] panel_width;
		logic [8:0] panel_height;
		logic [1:0] rotation;
	} cfg_t;

	// Byte sequence that one queued descriptor expands into.
	typedef enum logic [1:0] {
		KIND_WIN,      // window header, 11 bytes
		KIND_WIN_PIX,  // window header and one pixel, 13 bytes
		KIND_PAIR,     // two bytes: hi then lo
		KIND_ONE       // one byte: hi
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic        hi_cmd;
		logic        rect_done;
		logic [15:0] color;
		logic [15:0] sx;
		logic [15:0] ex;
		logic [15:0] sy;
		logic [15:0] ey;
	} desc_t;

endpackage

[rtl/lcd_window_command_stream.sv]
// Top level of the LCD window command stream: configuration registers, front end,
// descriptor queue and byte serializer. Uses lwcs_pkg, lwcs_front, lwcs_queue, lwcs_back.
//
//   Channel   Direction  Beat contents
//   s_*       in         tuser: action; tdata: x, y, rect_width, rect_height, color, invert_on
//   m_*       out        tdata: byte_value; tuser: is_command, rect_done; tlast: last
//   APB       in/out     panel_width @0x0, panel_height @0x4, rotation @0x8
//
// The front end takes one request beat per cycle while the queue has room; the
// output carries one byte per cycle while the receiver is ready, so a next-pixel
// request costs two bytes, a fill header eleven, a pixel draw thirteen and an invert
// one. The output byte stream sets the sustained rate. The first byte of a request
// passes the stage register, which loads at the edge that accepts its beat, then
// the queue, then the output register.
// Reset is asynchronous and clears the handshake state, the fill counter and the
// registers to a 240 by 320 panel in rotation 0. Either side can stall without
// stopping the other until the four-entry queue fills or drains.
module lcd_window_command_stream import lwcs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [8:0] x, [17:9] y, [26:18] rect_width, [35:27] rect_height,
	// [51:36] color, [52] invert_on, [55:53] zero
	input  logic [55:0] s_tdata,
	// [2:0] action
	input  logic [2:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [7:0] byte_value
	output logic [7:0]  m_tdata,
	// [0] is_command, [1] rect_done
	output logic [1:0]  m_tuser,
	output logic        m_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	// Configuration registers. Writes land on the access cycle; the derived
	// geometry in the front end is registered from them in the cycle after.
	cfg_t cfg_q;
	logic cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.panel_width  <= 8'd240;
			cfg_q.panel_height <= 9'd320;
			cfg_q.rotation     <= 2'd0;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_PANEL_WIDTH:  cfg_q.panel_width  <= pwdata[7:0];
				REG_PANEL_HEIGHT: cfg_q.panel_height <= pwdata[8:0];
				REG_ROTATION:     cfg_q.rotation     <= pwdata[1:0];
				default:          ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_PANEL_WIDTH:  prdata = 32'(cfg_q.panel_width);
			REG_PANEL_HEIGHT: prdata = 32'(cfg_q.panel_height);
			REG_ROTATION:     prdata = 32'(cfg_q.rotation);
			default:          prdata = '0;
		endcase
	end

	// Front end to queue.
	logic  push, push_ready;
	desc_t push_desc;

	lwcs_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.action      (s_tuser),
		.x           (s_tdata[8:0]),
		.y           (s_tdata[17:9]),
		.rect_width  (s_tdata[26:18]),
		.rect_height (s_tdata[35:27]),
		.color       (s_tdata[51:36]),
		.invert_on   (s_tdata[52]),
		.push        (push),
		.push_desc   (push_desc),
		.push_ready  (push_ready)
	);

	// Queue to serializer.
	logic  pop, head_valid;
	desc_t head_desc;

	lwcs_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_desc  (push_desc),
		.push_ready (push_ready),
		.pop        (pop),
		.head_valid (head_valid),
		.head_desc  (head_desc)
	);

	lwcs_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_desc  (head_desc),
		.pop        (pop),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.byte_value (m_tdata),
		.is_command (m_tuser[0]),
		.last       (m_tlast),
		.rect_done  (m_tuser[1])
	);

`ifndef SYNTHESIS
	// The front end never pushes into a full queue.
	assert property (@(posedge clk) disable iff (!arst_n) push |-> push_ready)
		else $error("descriptor pushed into a full queue");

	// The serializer only pops a descriptor that is present.
	assert property (@(posedge clk) disable iff (!arst_n) pop |-> head_valid)
		else $error("queue popped while empty");

	// The end of a fill is flagged only on the last data byte of a run.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[1]) |-> (m_tlast && !m_tuser[0]))
		else $error("rect_done outside the last data byte");

	// A beat that waits for the receiver keeps its contents.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable({m_tdata, m_tuser, m_tlast})))
		else $error("output beat changed while stalled");
`endif

endmodule

[rtl/lwcs_front.sv]
// Front end: accepts drawing requests, checks and clips them, keeps the fill state
// and pushes byte-sequence descriptors into the command queue. Uses lwcs_pkg.
module lwcs_front import lwcs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  action,
	input  logic [8:0]  x,
	input  logic [8:0]  y,
	input  logic [8:0]  rect_width,
	input  logic [8:0]  rect_height,
	input  logic [15:0] color,
	input  logic        invert_on,
	output logic        push,
	output desc_t       push_desc,
	input  logic        push_ready
);

	localparam int DW = OFF_W + 1;

	// Derived screen geometry, refreshed every cycle from the registers.
	logic [8:0]       vw_q, vh_q;
	logic [OFF_W-1:0] xoff_q, yoff_q;
	logic [7:0]       ori_q;

	logic [8:0]       vw_d, vh_d;
	logic [OFF_W-1:0] xoff_d, yoff_d;
	logic [7:0]       ori_d;

	function automatic logic [OFF_W-1:0] half_sat(logic [DW-1:0] a, logic [DW-1:0] b,
	                                             logic plus);
		logic [DW-1:0] d;
		d = a - b + DW'(plus);
		if (b > a)
			return '0;
		return OFF_W'(d >> 1);
	endfunction

	always_comb begin
		logic [DW-1:0]    rc, rr, pw_e, ph_e;
		logic [OFF_W-1:0] cs, cs2, rs, rs2;
		rc   = DW'(RAM_COLUMNS);
		rr   = DW'(RAM_ROWS);
		pw_e = DW'(cfg.panel_width);
		ph_e = DW'(cfg.panel_height);
		cs   = '0;
		cs2  = '0;
		rs   = '0;
		rs2  = '0;
		if (pw_e == rc && rr >= rc)
			rs = OFF_W'(rr - rc);
		if ({1'b0, cfg.panel_width} == ODD_SIZE || cfg.panel_height == ODD_SIZE) begin
			cs  = half_sat(rc, pw_e, 1'b1);
			cs2 = half_sat(rc, pw_e, 1'b0);
			rs  = half_sat(rr, ph_e, 1'b1);
			rs2 = half_sat(rr, ph_e, 1'b0);
		end
		unique case (cfg.rotation)
			2'd0: begin
				vw_d = {1'b0, cfg.panel_width}; vh_d = cfg.panel_height;
				xoff_d = cs; yoff_d = rs; ori_d = ORI_MX | ORI_MY | ORI_BGR;
			end
			2'd1: begin
				vw_d = cfg.panel_height; vh_d = {1'b0, cfg.panel_width};
				xoff_d = rs; yoff_d = cs2; ori_d = ORI_MY | ORI_MV | ORI_BGR;
			end
			2'd2: begin
				vw_d = {1'b0, cfg.panel_width}; vh_d = cfg.panel_height;
				xoff_d = cs2; yoff_d = rs2; ori_d = ORI_BGR;
			end
			default: begin
				vw_d = cfg.panel_height; vh_d = {1'b0, cfg.panel_width};
				xoff_d = rs2; yoff_d = cs; ori_d = ORI_MX | ORI_MV | ORI_BGR;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		vw_q   <= vw_d;
		vh_q   <= vh_d;
		xoff_q <= xoff_d;
		yoff_q <= yoff_d;
		ori_q  <= ori_d;
	end

	// Classification of the incoming request.
	logic        emit0, is_fill0, is_next0, hi_cmd0;
	kind_t       kind0;
	logic [8:0]  cw0, ch0;
	logic [15:0] color0;

	always_comb begin
		logic       on;
		logic [9:0] xe, ye;
		on  = (x < vw_q) && (y < vh_q);
		xe  = {1'b0, x} + {1'b0, rect_width} - 10'd1;
		ye  = {1'b0, y} + {1'b0, rect_height} - 10'd1;
		emit0    = 1'b0;
		is_fill0 = 1'b0;
		is_next0 = 1'b0;
		hi_cmd0  = 1'b0;
		kind0    = KIND_PAIR;
		cw0      = 9'd1;
		ch0      = 9'd1;
		color0   = color;
		unique case (action)
			ACT_FILL: begin
				emit0    = on && rect_width != '0 && rect_height != '0;
				is_fill0 = 1'b1;
				kind0    = KIND_WIN;
				cw0      = (xe >= {1'b0, vw_q}) ? vw_q - x : rect_width;
				ch0      = (ye >= {1'b0, vh_q}) ? vh_q - y : rect_height;
			end
			ACT_DRAW: begin
				emit0 = on;
				kind0 = KIND_WIN_PIX;
			end
			ACT_NEXT: begin
				emit0    = 1'b1;
				is_next0 = 1'b1;
			end
			ACT_INVERT: begin
				emit0   = 1'b1;
				kind0   = KIND_ONE;
				hi_cmd0 = 1'b1;
				color0  = {invert_on ? OP_INVON : OP_INVOFF, 8'h00};
			end
			ACT_ORIENT: begin
				emit0   = 1'b1;
				hi_cmd0 = 1'b1;
				color0  = {OP_MADCTL, ori_q};
			end
			default: emit0 = 1'b0;
		endcase
	end

	// Stage 1: registered request, resolved against the fill state on push.
	logic        valid_s1;
	logic        is_fill_s1, is_next_s1, hi_cmd_s1;
	kind_t       kind_s1;
	logic [8:0]  cw_s1, ch_s1;
	logic [15:0] color_s1, sx_s1, sy_s1;

	logic [16:0] pixels_left_q;
	logic [15:0] fill_color_q;

	logic        need_push, go_s1;
	logic [17:0] area;

	assign need_push = !(is_next_s1 && pixels_left_q == '0);
	assign go_s1     = !need_push || push_ready;
	assign in_ready  = !valid_s1 || go_s1;
	assign push      = valid_s1 && need_push && push_ready;
	assign area      = cw_s1 * ch_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid && emit0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready) begin
			is_fill_s1 <= is_fill0;
			is_next_s1 <= is_next0;
			hi_cmd_s1  <= hi_cmd0;
			kind_s1    <= kind0;
			cw_s1      <= cw0;
			ch_s1      <= ch0;
			color_s1   <= color0;
			sx_s1      <= 16'(x) + 16'(xoff_q);
			sy_s1      <= 16'(y) + 16'(yoff_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixels_left_q <= '0;
			fill_color_q  <= '0;
		end else if (valid_s1 && go_s1) begin
			if (is_fill_s1) begin
				pixels_left_q <= area[16:0];
				fill_color_q  <= color_s1;
			end else if (is_next_s1 && pixels_left_q != '0) begin
				pixels_left_q <= pixels_left_q - 17'd1;
			end
		end
	end

	always_comb begin
		push_desc.kind      = kind_s1;
		push_desc.hi_cmd    = hi_cmd_s1;
		push_desc.rect_done = is_next_s1 && pixels_left_q == 17'd1;
		push_desc.color     = is_next_s1 ? fill_color_q : color_s1;
		push_desc.sx        = sx_s1;
		push_desc.ex        = sx_s1 + 16'(cw_s1) - 16'd1;
		push_desc.sy        = sy_s1;
		push_desc.ey        = sy_s1 + 16'(ch_s1) - 16'd1;
	end

endmodule

[rtl/lwcs_queue.sv]
// Short descriptor queue that decouples the front end from the byte serializer.
// Uses desc_t and the depth constants of lwcs_pkg.
module lwcs_queue import lwcs_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  desc_t push_desc,
	output logic  push_ready,
	input  logic  pop,
	output logic  head_valid,
	output desc_t head_desc
);

	desc_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0]  count_q;

	assign push_ready = count_q != QCNT_W'(QUEUE_DEPTH);
	assign head_valid = count_q != '0;
	assign head_desc  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_desc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			if (push && !pop)
				count_q <= count_q + QCNT_W'(1);
			else if (pop && !push)
				count_q <= count_q - QCNT_W'(1);
		end
	end

endmodule

[rtl/lwcs_back.sv]
// Back end: expands the queue head into command and data bytes, one per cycle
// unless stalled, via a registered output stage. Uses desc_t and command codes of lwcs_pkg.
module lwcs_back import lwcs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       head_valid,
	input  desc_t      head_desc,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] byte_value,
	output logic       is_command,
	output logic       last,
	output logic       rect_done
);

	// Byte positions inside a window header and its pixel.
	localparam logic [3:0] POS_CASET = 4'd0;
	localparam logic [3:0] POS_SX_HI = 4'd1;
	localparam logic [3:0] POS_SX_LO = 4'd2;
	localparam logic [3:0] POS_EX_HI = 4'd3;
	localparam logic [3:0] POS_EX_LO = 4'd4;
	localparam logic [3:0] POS_RASET = 4'd5;
	localparam logic [3:0] POS_SY_HI = 4'd6;
	localparam logic [3:0] POS_SY_LO = 4'd7;
	localparam logic [3:0] POS_EY_HI = 4'd8;
	localparam logic [3:0] POS_EY_LO = 4'd9;
	localparam logic [3:0] POS_RAMWR = 4'd10;
	localparam logic [3:0] POS_PX_HI = 4'd11;
	localparam logic [3:0] POS_PX_LO = 4'd12;

	logic [3:0] pos_q;
	logic       valid_q;
	logic [7:0] byte_q;
	logic       cmd_q, last_q, done_q;

	logic [7:0] byte_d;
	logic       cmd_d, at_end, load;
	logic [3:0] end_pos;

	always_comb begin
		byte_d = 8'h00;
		cmd_d  = 1'b0;
		unique case (head_desc.kind)
			KIND_PAIR, KIND_ONE: begin
				end_pos = (head_desc.kind == KIND_ONE) ? 4'd0 : 4'd1;
				if (pos_q == 4'd0) begin
					byte_d = head_desc.color[15:8];
					cmd_d  = head_desc.hi_cmd;
				end else begin
					byte_d = head_desc.color[7:0];
				end
			end
			default: begin
				end_pos = (head_desc.kind == KIND_WIN) ? POS_RAMWR : POS_PX_LO;
				unique case (pos_q)
					POS_CASET: begin byte_d = OP_CASET; cmd_d = 1'b1; end
					POS_SX_HI: byte_d = head_desc.sx[15:8];
					POS_SX_LO: byte_d = head_desc.sx[7:0];
					POS_EX_HI: byte_d = head_desc.ex[15:8];
					POS_EX_LO: byte_d = head_desc.ex[7:0];
					POS_RASET: begin byte_d = OP_RASET; cmd_d = 1'b1; end
					POS_SY_HI: byte_d = head_desc.sy[15:8];
					POS_SY_LO: byte_d = head_desc.sy[7:0];
					POS_EY_HI: byte_d = head_desc.ey[15:8];
					POS_EY_LO: byte_d = head_desc.ey[7:0];
					POS_RAMWR: begin byte_d = OP_RAMWR; cmd_d = 1'b1; end
					POS_PX_HI: byte_d = head_desc.color[15:8];
					POS_PX_LO: byte_d = head_desc.color[7:0];
					default:   byte_d = 8'h00;
				endcase
			end
		endcase
	end

	assign at_end = pos_q == end_pos;
	assign load   = head_valid && (!valid_q || out_ready);
	assign pop    = load && at_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			pos_q   <= '0;
		end else begin
			if (load)
				pos_q <= at_end ? 4'd0 : pos_q + 4'd1;
			if (load)
				valid_q <= 1'b1;
			else if (out_ready)
				valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q <= byte_d;
			cmd_q  <= cmd_d;
			last_q <= at_end;
			done_q <= at_end && head_desc.rect_done;
		end
	end

	assign out_valid  = valid_q;
	assign byte_value = byte_q;
	assign is_command = cmd_q;
	assign last       = last_q;
	assign rect_done  = done_q;

endmodule
